>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define LBD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lbd_pkg.sv
// Shared types and constants of the label boundary detector.
`timescale 1ns / 1ps

package lbd_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_SIZE_BITS  = 11;
    localparam int CFG_HALF_BITS  = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_WINDOW_HALF  = 2'd2
    } t_cfg_index;

    localparam logic [CFG_SIZE_BITS-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_SIZE_BITS-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [CFG_HALF_BITS-1:0] RST_WINDOW_HALF  = 3'd1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic boundary;
        logic row_end;
        logic frame_end;
    } t_result;

endpackage

>>> rtl/lbd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lbd_out_fifo.sv
// Small result queue between the compare stage and the output channel.
`timescale 1ns / 1ps

module lbd_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  lbd_pkg::t_result           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output lbd_pkg::t_result           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    import lbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

>>> rtl/label_boundary_detector_core.sv
// Label boundary detector top level: line stores, window register, compare stage.
`timescale 1ns / 1ps

// Takes a label map one pixel per transaction in raster order and marks each
// pixel as boundary when any label in its clipped window (rows r-w..r+w-1,
// columns c-w..c+w-1) differs from its own. Sustained rate is one transaction
// per clock on both channels; a result passes through stage A and stage B
// into a four-entry result queue, so input keeps flowing while a result
// waits. The input stalls only when the queue plus the two results in flight
// would overfill it. The first result of a frame comes with input item
// (w-1)*width+(w-1); after the last pixel, drain transactions (func = 1) push
// out the rest, and the result with frame_end restarts the frame. Drains
// before the frame is in, and pixels while draining, are taken and ignored.
// The 2*MAX_HALF-1 line stores are RAMs of MAX_WIDTH labels each, read and
// rewritten once per transaction at the current column; a one-column frame
// forwards the last write around the RAM. A configuration write to any of
// the three registers restarts the frame; out-of-range register values are
// saturated into their used range.
module label_boundary_detector_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_HALF   = 4,
    parameter int LABEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic signed [LABEL_BITS-1:0]        i_label,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_boundary,
    output logic                                o_row_end,
    output logic                                o_frame_end,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lbd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lbd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    import lbd_pkg::*;

    localparam int CB         = $clog2(MAX_WIDTH);        // column index
    localparam int RB         = $clog2(MAX_HEIGHT);       // row index
    localparam int WW         = $clog2(MAX_WIDTH + 1);    // width value
    localparam int HTW        = $clog2(MAX_HEIGHT + 1);   // height value
    localparam int HB         = $clog2(MAX_HALF + 1);     // half size value
    localparam int WIN        = 2 * MAX_HALF;             // window edge
    localparam int KB         = $clog2(WIN);              // window slot index
    localparam int NL         = WIN - 1;                  // line stores
    localparam int MAX_DELAY  = (MAX_HALF - 1) * MAX_WIDTH + MAX_HALF - 1;
    localparam int DB         = $clog2(MAX_DELAY + 2);
    localparam int SW         = $clog2(MAX_WIDTH + WIN + 1);
    localparam int SR         = $clog2(MAX_HEIGHT + WIN + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FB         = $clog2(FIFO_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_SIZE_BITS-1:0] r_cfg_width;
    logic [CFG_SIZE_BITS-1:0] r_cfg_height;
    logic [CFG_HALF_BITS-1:0] r_cfg_half;
    logic                     cfg_wr;
    logic                     cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (t_cfg_index'(i_cfg_index))
            CFG_FRAME_WIDTH,
            CFG_FRAME_HEIGHT,
            CFG_WINDOW_HALF: cfg_hit = cfg_wr;
            default:         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_FRAME_WIDTH;
            r_cfg_height <= RST_FRAME_HEIGHT;
            r_cfg_half   <= RST_WINDOW_HALF;
        end else if (cfg_wr) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_SIZE_BITS-1:0];
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[CFG_SIZE_BITS-1:0];
                CFG_WINDOW_HALF:  r_cfg_half   <= i_cfg_data[CFG_HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Saturated working values; the user keeps them static while items flow, the block does not enforce it.
    logic [WW-1:0]  wd;
    logic [HTW-1:0] ht;
    logic [HB-1:0]  hw;
    logic [CB-1:0]  wd_m1;
    logic [RB-1:0]  ht_m1;
    logic [DB-1:0]  delay;

    always_comb begin
        if (r_cfg_width == '0) begin
            wd = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            wd = WW'(MAX_WIDTH);
        end else begin
            wd = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            ht = HTW'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            ht = HTW'(MAX_HEIGHT);
        end else begin
            ht = HTW'(r_cfg_height);
        end
        if (r_cfg_half == '0) begin
            hw = HB'(1);
        end else if (32'(r_cfg_half) > MAX_HALF) begin
            hw = HB'(MAX_HALF);
        end else begin
            hw = HB'(r_cfg_half);
        end
        wd_m1 = CB'(wd - WW'(1));
        ht_m1 = RB'(ht - HTW'(1));
        delay = DB'((32'(hw) - 32'd1) * 32'(wd) + 32'(hw) - 32'd1);
    end

    // ------------------------------------------------------------------
    // Stream position counters
    // ------------------------------------------------------------------
    logic          accept;
    logic          act;         // transaction that advances the stream
    logic          emit;        // ... and produces a result
    logic          oc_last;
    logic          or_last;
    logic          frame_last;

    logic [CB-1:0] r_in_col;    // column of the incoming item (wraps on drains)
    logic [RB-1:0] r_in_row;
    logic          r_in_done;   // all pixels of the frame are in
    logic [DB-1:0] r_lead;      // items seen before the first result
    logic          r_emitting;
    logic [CB-1:0] r_oc;        // coordinates of the next result pixel
    logic [RB-1:0] r_or;

    logic [CB-1:0] n_in_col;
    logic [RB-1:0] n_in_row;
    logic          n_in_done;
    logic [DB-1:0] n_lead;
    logic          n_emitting;
    logic [CB-1:0] n_oc;
    logic [RB-1:0] n_or;

    assign accept     = i_valid && !o_stall;
    assign act        = accept && (r_in_done ? (i_func == FUNC_DRAIN)
                                             : (i_func == FUNC_PIXEL));
    assign emit       = act && (r_emitting || (r_lead == delay));
    assign oc_last    = (r_oc == wd_m1);
    assign or_last    = (r_or == ht_m1);
    assign frame_last = emit && oc_last && or_last;

    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_done  = r_in_done;
        n_lead     = r_lead;
        n_emitting = r_emitting;
        n_oc       = r_oc;
        n_or       = r_or;
        if (cfg_hit || frame_last) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_in_done  = 1'b0;
            n_lead     = '0;
            n_emitting = 1'b0;
            n_oc       = '0;
            n_or       = '0;
        end else if (act) begin
            n_in_col = (r_in_col == wd_m1) ? '0 : r_in_col + CB'(1);
            if (!r_in_done && (r_in_col == wd_m1)) begin
                if (r_in_row == ht_m1) begin
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = r_in_row + RB'(1);
                end
            end
            if (emit) begin
                n_emitting = 1'b1;
                if (oc_last) begin
                    n_oc = '0;
                    n_or = r_or + RB'(1);
                end else begin
                    n_oc = r_oc + CB'(1);
                end
            end else begin
                n_lead = r_lead + DB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_done  <= 1'b0;
            r_lead     <= '0;
            r_emitting <= 1'b0;
            r_oc       <= '0;
            r_or       <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_done  <= n_in_done;
            r_lead     <= n_lead;
            r_emitting <= n_emitting;
            r_oc       <= n_oc;
            r_or       <= n_or;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: item register, line store read data, column assembly
    // ------------------------------------------------------------------
    logic                  r_a_act;
    logic                  r_a_emit;
    logic [LABEL_BITS-1:0] r_a_label;
    logic [CB-1:0]         r_a_col;
    logic [CB-1:0]         r_a_c;
    logic [RB-1:0]         r_a_r;
    logic                  r_a_row_end;
    logic                  r_a_frame_end;
    logic                  r_fwd;
    logic                  n_fwd;
    logic [LABEL_BITS-1:0] r_fwd_data [NL];

    logic [LABEL_BITS-1:0] ram_q  [NL];
    logic [LABEL_BITS-1:0] line_q [NL];
    logic [LABEL_BITS-1:0] vc     [WIN];   // vertical column, newest row first

    // A one-pixel-wide frame reads the column that stage A writes this cycle.
    assign n_fwd = r_a_act && act && (r_in_col == r_a_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_act  <= 1'b0;
            r_a_emit <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_a_act  <= act;
            r_a_emit <= emit;
            r_fwd    <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_label     <= i_label;
        r_a_col       <= r_in_col;
        r_a_c         <= r_oc;
        r_a_r         <= r_or;
        r_a_row_end   <= oc_last;
        r_a_frame_end <= oc_last && or_last;
        for (int k = 0; k < NL; k++) begin
            r_fwd_data[k] <= vc[k];
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_line
        lbd_ram #(
            .WIDTH (LABEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (r_a_act),
            .i_waddr (r_a_col),
            .i_wdata (vc[g]),
            .i_re    (act),
            .i_raddr (r_in_col),
            .o_rdata (ram_q[g])
        );
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            line_q[k] = r_fwd ? r_fwd_data[k] : ram_q[k];
        end
        vc[0] = r_a_label;
        for (int j = 1; j < WIN; j++) begin
            vc[j] = line_q[j-1];
        end
    end

    // Window validity of the result pixel: slot k is column c+w-1-k, slot
    // row j is row r+w-1-j; both must fall inside the frame and the 2w span.
    logic [SW-1:0]  a_cpos;
    logic [SR-1:0]  a_rpos;
    logic [WIN-1:0] a_col_ok;
    logic [WIN-1:0] a_row_ok;

    always_comb begin
        a_cpos = SW'(r_a_c) + SW'(hw) - SW'(1);
        a_rpos = SR'(r_a_r) + SR'(hw) - SR'(1);
        for (int k = 0; k < WIN; k++) begin
            a_col_ok[k] = (SW'(k) < (SW'(hw) + SW'(hw))) && (SW'(k) <= a_cpos)
                       && (a_cpos < (SW'(wd) + SW'(k)));
            a_row_ok[k] = (SR'(k) < (SR'(hw) + SR'(hw))) && (SR'(k) <= a_rpos)
                       && (a_rpos < (SR'(ht) + SR'(k)));
        end
    end

    // Window register: one vertical column per stream item, newest in slot 0.
    logic [LABEL_BITS-1:0] r_win [WIN][WIN];

    always_ff @(posedge i_clk) begin
        if (r_a_act) begin
            r_win[0] <= vc;
            for (int k = 1; k < WIN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: compare every window label against the pixel's own label
    // ------------------------------------------------------------------
    logic                  r_b_emit;
    logic [WIN-1:0]        r_b_col_ok;
    logic [WIN-1:0]        r_b_row_ok;
    logic                  r_b_row_end;
    logic                  r_b_frame_end;
    logic [KB-1:0]         own_idx;
    logic [LABEL_BITS-1:0] own_label;
    logic                  b_diff;
    t_result               b_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_emit <= 1'b0;
        end else begin
            r_b_emit <= r_a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_col_ok    <= a_col_ok;
        r_b_row_ok    <= a_row_ok;
        r_b_row_end   <= r_a_row_end;
        r_b_frame_end <= r_a_frame_end;
    end

    assign own_idx   = KB'(hw - HB'(1));
    assign own_label = r_win[own_idx][own_idx];

    always_comb begin
        b_diff = 1'b0;
        for (int k = 0; k < WIN; k++) begin
            for (int j = 0; j < WIN; j++) begin
                if (r_b_col_ok[k] && r_b_row_ok[j] && (r_win[k][j] != own_label)) begin
                    b_diff = 1'b1;
                end
            end
        end
        b_result.boundary  = b_diff;
        b_result.row_end   = r_b_row_end;
        b_result.frame_end = r_b_frame_end;
    end

    // ------------------------------------------------------------------
    // Result queue and flow control
    // ------------------------------------------------------------------
    t_result       q_data;
    logic [FB-1:0] q_count;
    logic          q_pop;
    logic [FB:0]   credit_used;

    assign q_pop = o_valid && !i_stall;

    lbd_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_emit),
        .i_data  (b_result),
        .i_pop   (q_pop),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    // Results still in stages A and B hold a queue slot each.
    assign credit_used = (FB+1)'(q_count) + (FB+1)'(r_a_emit) + (FB+1)'(r_b_emit);
    assign o_stall     = (credit_used >= (FB+1)'(FIFO_DEPTH));

    assign o_boundary  = q_data.boundary;
    assign o_row_end   = q_data.row_end;
    assign o_frame_end = q_data.frame_end;

endmodule

>>> rtl/lbd_checker.sv
// Port-level assertions for the label boundary detector and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbd_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_boundary,
    input logic o_row_end,
    input logic o_frame_end
);

    `LBD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid,
        "result dropped while stalled")
    `LBD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_boundary) && $stable(o_row_end) && $stable(o_frame_end),
        "stalled result changed")
    `LBD_ASSERT_IMPLY(a_frame_end_row_end, i_clk, i_rst_n, o_valid && o_frame_end, o_row_end,
        "frame end without row end")
    `LBD_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid && !o_stall,
        "not idle after reset")

endmodule

bind label_boundary_detector_core lbd_port_checker u_lbd_checker (.*);

>>> sim/lbd_checker.sv
// Checker for the label boundary detector: predicts boundary flags and compares results.
`timescale 1ns / 1ps

module lbd_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_HALF   = 4,
    parameter int LABEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_in_func,
    input  logic [LABEL_BITS-1:0]               i_in_label,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_boundary,
    input  logic                                i_row_end,
    input  logic                                i_frame_end,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [lbd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lbd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import lbd_pkg::*;

    // spans the oldest label any window can still need
    localparam int STORE_DEPTH = 8192;
    localparam int MAX_REPORTS = 10;

    logic [CFG_SIZE_BITS-1:0] width_reg;
    logic [CFG_SIZE_BITS-1:0] height_reg;
    logic [CFG_HALF_BITS-1:0] half_reg;
    logic [LABEL_BITS-1:0]    label_store [STORE_DEPTH];
    int unsigned              stream_pos;
    t_result                  boundary_due [$];
    int                       fail_count;
    int                       result_num;

    function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // half-open window: rows r-hw..r+hw-1, columns c-hw..c+hw-1, clipped
    function automatic logic window_differs(input int unsigned r, input int unsigned c,
                                            input int unsigned wd, input int unsigned ht,
                                            input int unsigned hw);
        logic [LABEL_BITS-1:0] own;
        int unsigned r_lo, r_hi, c_lo, c_hi;
        own  = label_store[(r * wd + c) % STORE_DEPTH];
        r_lo = (r >= hw) ? r - hw : 0;
        r_hi = (r + hw < ht) ? r + hw : ht;
        c_lo = (c >= hw) ? c - hw : 0;
        c_hi = (c + hw < wd) ? c + hw : wd;
        for (int unsigned r1 = r_lo; r1 < r_hi; r1++)
            for (int unsigned c1 = c_lo; c1 < c_hi; c1++)
                if (label_store[(r1 * wd + c1) % STORE_DEPTH] != own) return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_boundary(input logic func, input logic [LABEL_BITS-1:0] lab);
        int unsigned wd, ht, hw, total, lag, n, p;
        t_result res;
        wd    = saturate(width_reg, MAX_WIDTH);
        ht    = saturate(height_reg, MAX_HEIGHT);
        hw    = saturate(half_reg, MAX_HALF);
        total = wd * ht;
        lag   = (hw - 1) * wd + (hw - 1);
        n     = stream_pos;
        if (n < total) begin
            if (func != FUNC_PIXEL) return;   // drain before the frame is in
            label_store[n % STORE_DEPTH] = lab;
        end else if (func == FUNC_PIXEL) begin
            return;                           // pixel while draining
        end
        stream_pos = n + 1;
        if (n < lag) return;
        p = n - lag;
        res.boundary  = window_differs(p / wd, p % wd, wd, ht, hw);
        res.row_end   = (p % wd == wd - 1);
        res.frame_end = (p == total - 1);
        if (res.frame_end) stream_pos = 0;
        boundary_due.push_back(res);
    endtask

    task automatic check_result();
        t_result want;
        result_num++;
        if (boundary_due.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $display("result %0d: no result expected (boundary %b row_end %b frame_end %b)",
                         result_num, i_boundary, i_row_end, i_frame_end);
            fail_count++;
            return;
        end
        want = boundary_due.pop_front();
        if (i_boundary !== want.boundary || i_row_end !== want.row_end ||
            i_frame_end !== want.frame_end) begin
            if (fail_count < MAX_REPORTS)
                $display("result %0d: boundary exp %b got %b, row_end exp %b got %b, %s %b got %b",
                         result_num, want.boundary, i_boundary, want.row_end, i_row_end,
                         "frame_end exp", want.frame_end, i_frame_end);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            half_reg   = RST_WINDOW_HALF;
            stream_pos = 0;
            fail_count = 0;
            result_num = 0;
            boundary_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg  = i_cfg_data[CFG_SIZE_BITS-1:0];
                        stream_pos = 0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data[CFG_SIZE_BITS-1:0];
                        stream_pos = 0;
                    end
                    CFG_WINDOW_HALF: begin
                        half_reg   = i_cfg_data[CFG_HALF_BITS-1:0];
                        stream_pos = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_boundary(i_in_func, i_in_label);
            if (i_out_valid && !i_out_stall) check_result();
        end
        o_pending    <= boundary_due.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> sim/testbench.sv
// Testbench top for the label boundary detector: stimulus, receiver throttling and verdict.
`timescale 1ns / 1ps

module testbench;
    import lbd_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_HALF     = 4;
    localparam int LABEL_BITS   = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 450;
    // the oversize frames are abandoned after this many stream items
    localparam int EXTREME_CUT  = 120;
    // cycles allowed for work still in flight once nothing is expected
    localparam int SETTLE       = 8;

    // index with no register behind it: written but expected to change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    // directed 4x3 map: two flat regions over a mixed bottom row, label extremes
    localparam logic [11:0][15:0] DIR_LABELS = {
        16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
        16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
        16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_func   = FUNC_PIXEL;
    logic [LABEL_BITS-1:0]     in_label  = '0;
    logic                      rx_stall  = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    logic o_stall, o_valid, o_boundary, o_row_end, o_frame_end, o_cfg_ready;

    int          pending;
    int          fail_count;
    int unsigned cycle_count = 0;

    // idle_en gates the random bursts on both channels; long_hold_req asks the
    // receiver for one long hold-off
    bit idle_en       = 1'b1;
    bit long_hold_req = 1'b0;

    // frame geometry as the block will see it after saturation
    int frame_wd, frame_ht, frame_hw;
    int counted;

    label_boundary_detector_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_HALF   (MAX_HALF),
        .LABEL_BITS (LABEL_BITS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (o_stall),
        .i_func      (in_func),
        .i_label     (in_label),
        .o_valid     (o_valid),
        .i_stall     (rx_stall),
        .o_boundary  (o_boundary),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lbd_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_HALF   (MAX_HALF),
        .LABEL_BITS (LABEL_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_stall),
        .i_in_func    (in_func),
        .i_in_label   (in_label),
        .i_out_valid  (o_valid),
        .i_out_stall  (rx_stall),
        .i_boundary   (o_boundary),
        .i_row_end    (o_row_end),
        .i_frame_end  (o_frame_end),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side throttling. Short random bursts while idling is enabled;
    // one long hold-off on request so the result queue fills and the block
    // pushes back on its pixel input.
    initial begin
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rx_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                rx_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rx_stall <= 1'b0;
            end
        end
    end

    function automatic int clip(input int v, input int hi);
        return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    // One pixel-channel transaction. Optional bubble first; the payload then
    // stays put until the block takes it.
    task automatic send_item(input logic func, input logic [LABEL_BITS-1:0] lab);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= func;
        in_label <= lab;
        @(posedge clk);
        while (o_stall !== 1'b0) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (o_cfg_ready !== 1'b1) @(posedge clk);
    endtask

    // Input quiet, every result back, then a settling wait for ignored
    // transactions still in the pipe.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Raw values go to the block as given; out-of-range ones get saturated there.
    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] w,
                                input logic [CFG_DATA_BITS-1:0] h,
                                input logic [CFG_DATA_BITS-1:0] half,
                                input bit spare);
        if (spare) cfg_write(CFG_UNUSED_INDEX, CFG_DATA_BITS'($urandom));
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_WINDOW_HALF, half);
        cfg_valid <= 1'b0;
        frame_wd = clip(int'(w), MAX_WIDTH);
        frame_ht = clip(int'(h), MAX_HEIGHT);
        frame_hw = clip(int'(half[CFG_HALF_BITS-1:0]), MAX_HALF);
    endtask

    // One frame plus its drain tail. Labels form a two-label block pattern so
    // flat interiors and edges both show up, with the odd noisy pixel. Stray
    // drains among the pixels and stray pixels among the drains must be
    // dropped. pause_at: stop there, write the unused index, carry on (frame
    // must not restart). cut_at: abandon the stream there; the next register
    // write restarts the frame.
    task automatic send_frame(input int pause_at, input int cut_at);
        logic [LABEL_BITS-1:0] lab_a, lab_b, lab;
        int blk_w, blk_h, k, lag;
        lab_a = LABEL_BITS'($urandom);
        lab_b = ($urandom_range(0, 3) == 0) ? lab_a : LABEL_BITS'($urandom);
        blk_w = $urandom_range(1, frame_wd);
        blk_h = $urandom_range(1, frame_ht);
        lag   = (frame_hw - 1) * frame_wd + frame_hw - 1;
        k     = 0;
        for (int r = 0; r < frame_ht; r++) begin
            for (int c = 0; c < frame_wd; c++) begin
                if (k == cut_at) return;
                if (k == pause_at) begin
                    wait_idle();
                    cfg_write(CFG_UNUSED_INDEX, CFG_DATA_BITS'($urandom));
                    cfg_valid <= 1'b0;
                end
                if ($urandom_range(0, 31) == 0) send_item(FUNC_DRAIN, LABEL_BITS'($urandom));
                if ($urandom_range(0, 15) == 0)
                    lab = LABEL_BITS'($urandom);
                else
                    lab = (((r / blk_h) + (c / blk_w)) % 2 != 0) ? lab_b : lab_a;
                send_item(FUNC_PIXEL, lab);
                k++;
                counted++;
            end
        end
        for (int d = 0; d < lag; d++) begin
            if (k == cut_at) return;
            if ($urandom_range(0, 31) == 0) send_item(FUNC_PIXEL, LABEL_BITS'($urandom));
            send_item(FUNC_DRAIN, LABEL_BITS'($urandom));
            k++;
            counted++;
        end
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] w_raw, h_raw, half_raw;
        int n_frames, span, pause_at, cut_at;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: 4x3 frame, w=2 (first result after six pixels) ---
        program_regs(11'd4, 11'd3, 11'd2, 1'b0);
        send_item(FUNC_DRAIN, 16'h7FFF);            // drain while pixels are due
        for (int i = 0; i < 12; i++) send_item(FUNC_PIXEL, DIR_LABELS[11 - i]);
        send_item(FUNC_PIXEL, 16'h0000);            // pixel while draining
        repeat (5) send_item(FUNC_DRAIN, 16'h8000); // flush; last one ends the frame
        wait_idle();

        // zeros saturate to a 1x1 frame with w=1: every pixel is a whole frame
        program_regs(11'd0, 11'd0, 11'd0, 1'b0);
        send_item(FUNC_PIXEL, 16'hFFFF);
        send_item(FUNC_PIXEL, 16'h0001);
        wait_idle();

        // --- extremes ---
        // oversize width saturates to 1024; one-row frame with w=1 so every
        // pixel gives a result, and the long result hold-off lands in it;
        // the frame is abandoned part way
        program_regs(11'h7FF, 11'd1, 11'd1, 1'b1);
        long_hold_req = 1'b1;
        send_frame(-1, EXTREME_CUT);
        wait_idle();

        // oversize half saturates to 4 on a small frame
        program_regs(11'd5, 11'd3, 11'd7, 1'b0);
        send_frame(-1, -1);
        wait_idle();

        // one column, tallest frame, abandoned part way
        program_regs(11'd1, 11'h7FF, 11'd4, 1'b0);
        send_frame(-1, EXTREME_CUT);

        // --- random phases of small frames ---
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            wait_idle();
            idle_en  = ($urandom_range(0, 3) != 0);
            w_raw    = CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                                  : $urandom_range(1, 12));
            h_raw    = CFG_DATA_BITS'($urandom_range(1, 10));
            if ($urandom_range(0, 15) == 0) w_raw = '0;
            if ($urandom_range(0, 15) == 0) h_raw = '0;
            half_raw = CFG_DATA_BITS'($urandom_range(0, 15));
            program_regs(w_raw, h_raw, half_raw, $urandom_range(0, 7) == 0);
            n_frames = $urandom_range(1, 3);
            span     = frame_wd * frame_ht + (frame_hw - 1) * (frame_wd + 1);
            for (int f = 0; f < n_frames; f++) begin
                pause_at = ($urandom_range(0, 3) == 0)
                         ? $urandom_range(0, frame_wd * frame_ht - 1) : -1;
                cut_at   = (f == n_frames - 1 && $urandom_range(0, 4) == 0)
                         ? $urandom_range(0, span - 1) : -1;
                send_frame(pause_at, cut_at);
            end
        end

        // --- closing stretch: no bubbles, no stalls ---
        wait_idle();
        idle_en = 1'b0;
        program_regs(CFG_DATA_BITS'($urandom_range(2, 12)), CFG_DATA_BITS'($urandom_range(2, 8)),
                     CFG_DATA_BITS'($urandom_range(1, 4)), 1'b0);
        send_frame(-1, -1);
        send_frame(-1, -1);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> label_boundary_detector_core.f
+incdir+rtl
rtl/lbd_pkg.sv
rtl/lbd_ram.sv
rtl/lbd_out_fifo.sv
rtl/label_boundary_detector_core.sv
rtl/lbd_checker.sv
sim/lbd_checker.sv
sim/testbench.sv
